// ===== rtl/ttq_pkg.sv =====
package ttq_pkg;

	localparam int CAPACITY = 16;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		MODE_APPEND = 3'd0,
		MODE_DELETE = 3'd1,
		MODE_PAUSE  = 3'd2,
		MODE_RESUME = 3'd3,
		MODE_POP    = 3'd4,
		MODE_CHECK  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

	// Per-list command broadcast to every cell of one list.
	typedef struct packed {
		logic                   remove;
		logic                   append;
		logic [IDX_W-1:0]       pos;
		logic [HANDLE_BITS-1:0] data;
	} list_cmd_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] task_handle;
		logic [3:0]  position;
		logic        which_list;
	} in_item_t;

	typedef struct packed {
		logic [15:0] handle_out;
		logic        handle_valid;
		logic        found;
		logic        running_empty;
		logic [4:0]  running_count;
		logic [4:0]  paused_count;
		logic [1:0]  status;
	} out_item_t;

endpackage

// ===== rtl/ttq_if.sv =====
interface ttq_in_if;
	import ttq_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ttq_out_if;
	import ttq_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ttq_cell.sv =====
module ttq_cell import ttq_pkg::*; (
	input  logic                   clk,
	input  logic [IDX_W-1:0]       idx,
	input  logic [CNT_W-1:0]       size,
	input  list_cmd_t              cmd,
	input  logic [HANDLE_BITS-1:0] next_data,
	input  logic [HANDLE_BITS-1:0] rot_in,
	input  logic                   rotate,
	output logic [HANDLE_BITS-1:0] data
);
	logic [HANDLE_BITS-1:0] data_q;

	// A cell at or after the removed position takes its neighbor's value; the
	// cell at the tail takes an appended handle. Rotate shifts the whole row.
	always_ff @(posedge clk) begin
		if (rotate) begin
			data_q <= rot_in;
		end else if (cmd.remove && idx >= cmd.pos) begin
			data_q <= next_data;
		end else if (cmd.append && {1'b0, idx} == size) begin
			data_q <= cmd.data;
		end
	end

	assign data = data_q;
endmodule

// ===== rtl/ttq_list.sv =====
module ttq_list import ttq_pkg::*; (
	input  logic                   clk,
	input  list_cmd_t              cmd,
	input  logic [CNT_W-1:0]       size,
	input  logic                   rotate,
	input  logic [IDX_W-1:0]       sel,
	output logic [HANDLE_BITS-1:0] head,
	output logic [HANDLE_BITS-1:0] at_pos
);
	logic [HANDLE_BITS-1:0] cell_data [CAPACITY];
	// At removal the last cell keeps its own value, and removal wins over append.
	// Here append after remove in the same list never happens.

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [HANDLE_BITS-1:0] nxt;
		if (i == CAPACITY - 1) begin : g_last
			assign nxt = cell_data[i];
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		ttq_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.size     (size),
			.cmd      (cmd),
			.next_data(nxt),
			.rot_in   (cell_data[(i + 1) % CAPACITY]),
			.rotate   (rotate),
			.data     (cell_data[i])
		);
	end

	assign head = cell_data[0];
	assign at_pos = cell_data[sel];
endmodule

// ===== rtl/two_list_task_queue.sv =====
// Two ordered lists of task handles, running and paused, sharing a pool of
// CAPACITY entries. Commands arrive on the in channel (valid/ready); each
// accepted item produces exactly one result item on the out channel.
// Modes are append, delete, pause, resume, pop and check.
// Each list is a row of cells; removal shifts every later cell one place
// toward the head at once, append writes the tail cell.
// Check rotates both rows through all CAPACITY positions, comparing the head
// cell against the handle. One item is in work at a time; the next item is
// accepted in the cycle after the result has been taken.
// Reset clears both counts and the control state; cell contents are left
// undefined, and only cells below a list's count are ever read.
// When the receiver holds ready low, the result holds, no new result
// is loaded and no new item is accepted.
module two_list_task_queue import ttq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	ttq_in_if.sink  in_ch,
	ttq_out_if.source out_ch
);
	fsm_t                   state_q, state_d;
	in_item_t               item_q;
	logic [CNT_W-1:0]       run_size_q, pau_size_q;
	logic [IDX_W-1:0]       scan_q;
	logic                   found_q;
	logic                   out_valid_q;
	out_item_t              out_q;
	list_cmd_t              run_cmd, pau_cmd;
	logic                   rotate;
	logic [HANDLE_BITS-1:0] run_head, pau_head, run_at, pau_at;
	logic                   run_ok, pau_ok, full;
	logic                   exec;
	logic [CNT_W-1:0]       run_next, pau_next;
	out_item_t              res;

	assign in_ch.ready = (state_q == FSM_IDLE) && !out_valid_q;
	assign exec = (state_q == FSM_SCAN) && (item_q.mode != MODE_CHECK);
	assign rotate = (state_q == FSM_SCAN) && (item_q.mode == MODE_CHECK);

	assign run_ok = {1'b0, item_q.position} < run_size_q;
	assign pau_ok = {1'b0, item_q.position} < pau_size_q;
	assign full = (CNT_W+1)'(run_size_q) + (CNT_W+1)'(pau_size_q) >= (CNT_W+1)'(CAPACITY);

	ttq_list u_run (
		.clk(clk), .cmd(run_cmd), .size(run_size_q), .rotate(rotate),
		.sel(IDX_W'(item_q.position)), .head(run_head), .at_pos(run_at));
	ttq_list u_pau (
		.clk(clk), .cmd(pau_cmd), .size(pau_size_q), .rotate(rotate),
		.sel(IDX_W'(item_q.position)), .head(pau_head), .at_pos(pau_at));

	always_comb begin
		run_cmd = '0;
		pau_cmd = '0;
		run_cmd.pos = IDX_W'(item_q.position);
		pau_cmd.pos = IDX_W'(item_q.position);
		run_next = run_size_q;
		pau_next = pau_size_q;
		res = '0;
		if (exec) begin
			case (item_q.mode)
				MODE_APPEND: begin
					if (full) begin
						res.status = ST_FULL;
					end else begin
						run_cmd.append = 1'b1;
						run_cmd.data = HANDLE_BITS'(item_q.task_handle);
						run_next = run_size_q + CNT_W'(1);
					end
				end
				MODE_DELETE: begin
					if (!item_q.which_list) begin
						if (!run_ok) begin
							res.status = ST_RANGE;
						end else begin
							run_cmd.remove = 1'b1;
							run_next = run_size_q - CNT_W'(1);
						end
					end else begin
						if (!pau_ok) begin
							res.status = ST_RANGE;
						end else begin
							pau_cmd.remove = 1'b1;
							pau_next = pau_size_q - CNT_W'(1);
						end
					end
				end
				MODE_PAUSE: begin
					if (!run_ok) begin
						res.status = ST_RANGE;
					end else begin
						run_cmd.remove = 1'b1;
						run_next = run_size_q - CNT_W'(1);
						pau_cmd.append = 1'b1;
						pau_cmd.data = run_at;
						pau_next = pau_size_q + CNT_W'(1);
					end
				end
				MODE_RESUME: begin
					if (!pau_ok) begin
						res.status = ST_RANGE;
					end else begin
						pau_cmd.remove = 1'b1;
						pau_next = pau_size_q - CNT_W'(1);
						run_cmd.append = 1'b1;
						run_cmd.data = pau_at;
						run_next = run_size_q + CNT_W'(1);
					end
				end
				MODE_POP: begin
					if (run_size_q != '0) begin
						run_cmd.remove = 1'b1;
						run_cmd.pos = '0;
						run_next = run_size_q - CNT_W'(1);
						res.handle_out = 16'(run_head);
						res.handle_valid = 1'b1;
					end
				end
				default: ;
			endcase
		end
		res.found = found_q;
		res.running_empty = (run_next == '0);
		res.running_count = 5'(run_next);
		res.paused_count = 5'(pau_next);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (in_ch.valid && in_ch.ready) state_d = FSM_SCAN;
			FSM_SCAN: if (!rotate || scan_q == IDX_W'(CAPACITY - 1)) state_d = FSM_DONE;
			FSM_DONE: state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			run_size_q <= '0;
			pau_size_q <= '0;
			out_valid_q <= 1'b0;
			scan_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == FSM_IDLE && in_ch.valid && in_ch.ready) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end
			if (rotate) begin
				scan_q <= scan_q + IDX_W'(1);
				if (({1'b0, scan_q} < run_size_q && run_head == HANDLE_BITS'(item_q.task_handle))
					|| ({1'b0, scan_q} < pau_size_q
					&& pau_head == HANDLE_BITS'(item_q.task_handle)))
					found_q <= 1'b1;
			end
			if (state_q == FSM_DONE) begin
				out_valid_q <= 1'b1;
			end
			if (exec) begin
				run_size_q <= run_next;
				pau_size_q <= pau_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && in_ch.valid && in_ch.ready) item_q <= in_ch.data;
		if (state_q == FSM_DONE && item_q.mode == MODE_CHECK) out_q <= res;
		if (exec) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
endmodule

// ===== rtl/ttq_checker.sv =====
module ttq_checker import ttq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.running_count + out_data.paused_count <= 6'(CAPACITY)))
		else $error("pool overflow");
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.running_empty == (out_data.running_count == '0)))
		else $error("empty flag mismatch");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.handle_valid |-> !out_data.found && out_data.status == ST_OK)
		else $error("pop result mixed");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("accept while result pending");
endmodule

bind two_list_task_queue ttq_checker u_ttq_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
